// ===== hdl/biq_pkg.sv =====
// shared types and constants of the biquad low-pass filter
`timescale 1ns / 1ps

package biq_pkg;

  // digit width of the serial multiplier
  localparam int DIGIT_W = 4;

  // gain formats
  localparam int IN_GAIN_W  = 16;
  localparam int OUT_GAIN_W = 24;
  localparam int IN_FRAC    = 15;
  localparam int OUT_FRAC   = 20;

  // number of filter taps
  localparam int NUM_TAPS = 5;

  // register reset values that do not depend on the coefficient width
  localparam logic [IN_GAIN_W-1:0]  IN_GAIN_RST  = 16'd32768;
  localparam logic [OUT_GAIN_W-1:0] OUT_GAIN_RST = 24'd1048576;

  // configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FF0      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FF1      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FF2      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FB1      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FB2      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_IN_GAIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OUT_GAIN = 3'd6;

  // tap selection codes
  localparam int TAP_W = 3;
  localparam logic [TAP_W-1:0] TAP_FF0 = 3'd0;
  localparam logic [TAP_W-1:0] TAP_FF1 = 3'd1;
  localparam logic [TAP_W-1:0] TAP_FF2 = 3'd2;
  localparam logic [TAP_W-1:0] TAP_FB1 = 3'd3;
  localparam logic [TAP_W-1:0] TAP_FB2 = 3'd4;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LD_GAIN  = 8'b0000_0010,
    S_RUN_GAIN = 8'b0000_0100,
    S_LD_TAP   = 8'b0000_1000,
    S_RUN_TAP  = 8'b0001_0000,
    S_LD_OUT   = 8'b0010_0000,
    S_RUN_OUT  = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_e;

  // commands to the serial multiply-accumulate unit
  typedef struct packed {
    logic load;      // take new operands
    logic load_acc;  // preset the accumulator with the rounding constant
  } mac_cmd_t;

  // status of the serial multiply-accumulate unit
  typedef struct packed {
    logic busy;
    logic done;      // one cycle, accumulator holds the finished sum
  } mac_sts_t;

endpackage

// ===== hdl/biq_cfg.sv =====
// apb register file holding the filter coefficients and gains
`timescale 1ns / 1ps

module biq_cfg import biq_pkg::*; #(
  parameter int COEF_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic signed [COEF_BITS-1:0] coef_ff0_o,
  output logic signed [COEF_BITS-1:0] coef_ff1_o,
  output logic signed [COEF_BITS-1:0] coef_ff2_o,
  output logic signed [COEF_BITS-1:0] coef_fb1_o,
  output logic signed [COEF_BITS-1:0] coef_fb2_o,
  output logic [IN_GAIN_W-1:0]        in_gain_o,
  output logic [OUT_GAIN_W-1:0]       out_gain_o
);

  localparam logic [COEF_BITS-1:0] FF0_RST = {2'b01, {(COEF_BITS-2){1'b0}}};

  logic signed [COEF_BITS-1:0] ff0_q, ff1_q, ff2_q, fb1_q, fb2_q;
  logic [IN_GAIN_W-1:0]        in_gain_q;
  logic [OUT_GAIN_W-1:0]       out_gain_q;
  logic [REG_IDX_W-1:0]        idx;
  logic                        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff0_q      <= FF0_RST;
      ff1_q      <= '0;
      ff2_q      <= '0;
      fb1_q      <= '0;
      fb2_q      <= '0;
      in_gain_q  <= IN_GAIN_RST;
      out_gain_q <= OUT_GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_FF0:      ff0_q      <= pwdata[COEF_BITS-1:0];
        REG_FF1:      ff1_q      <= pwdata[COEF_BITS-1:0];
        REG_FF2:      ff2_q      <= pwdata[COEF_BITS-1:0];
        REG_FB1:      fb1_q      <= pwdata[COEF_BITS-1:0];
        REG_FB2:      fb2_q      <= pwdata[COEF_BITS-1:0];
        REG_IN_GAIN:  in_gain_q  <= pwdata[IN_GAIN_W-1:0];
        REG_OUT_GAIN: out_gain_q <= pwdata[OUT_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, coefficients sign extended
  always_comb begin
    case (idx)
      REG_FF0:      prdata = 32'(ff0_q);
      REG_FF1:      prdata = 32'(ff1_q);
      REG_FF2:      prdata = 32'(ff2_q);
      REG_FB1:      prdata = 32'(fb1_q);
      REG_FB2:      prdata = 32'(fb2_q);
      REG_IN_GAIN:  prdata = 32'(in_gain_q);
      REG_OUT_GAIN: prdata = 32'(out_gain_q);
      default:      prdata = '0;
    endcase
  end

  assign coef_ff0_o = ff0_q;
  assign coef_ff1_o = ff1_q;
  assign coef_ff2_o = ff2_q;
  assign coef_fb1_o = fb1_q;
  assign coef_fb2_o = fb2_q;
  assign in_gain_o  = in_gain_q;
  assign out_gain_o = out_gain_q;

endmodule

// ===== hdl/biq_mac.sv =====
// digit-serial signed multiply-accumulate unit
`timescale 1ns / 1ps

module biq_mac import biq_pkg::*; #(
  parameter int A_W   = 32,
  parameter int DIG_N = 8,
  parameter int ACC_W = 67
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mac_cmd_t                       cmd_i,
  input  logic signed [A_W-1:0]          a_i,
  input  logic [DIG_N*DIGIT_W-1:0]       b_i,
  input  logic signed [ACC_W-1:0]        acc_init_i,
  output mac_sts_t                       sts_o,
  output logic signed [ACC_W-1:0]        acc_o
);

  localparam int B_W   = DIG_N * DIGIT_W;
  localparam int CNT_W = $clog2(DIG_N);

  logic signed [ACC_W-1:0] m_q, acc_q, pp;
  logic [B_W-1:0]          b_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, done_q;
  logic                    last;
  logic [DIGIT_W:0]        dig;

  // low digit of the multiplier, the top digit carries the sign
  assign last = (cnt_q == '0);
  assign dig  = {last & b_q[DIGIT_W-1], b_q[DIGIT_W-1:0]};

  // partial product of the shifted multiplicand and one digit
  always_comb begin
    pp = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (dig[j]) pp = pp + (m_q <<< j);
    end
    if (dig[DIGIT_W]) pp = pp - (m_q <<< DIGIT_W);
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q <= ACC_W'(a_i);
      b_q <= b_i;
      if (cmd_i.load_acc) acc_q <= acc_init_i;
    end else if (busy_q) begin
      acc_q <= acc_q + pp;
      m_q   <= m_q <<< DIGIT_W;
      b_q   <= b_q >> DIGIT_W;
    end
  end

  // digit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIG_N - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;

endmodule

// ===== hdl/biquad_lowpass_filter.sv =====
// biquad low-pass filter top level: sequencer, history and output register
// Direct Form I second-order IIR filter for signed audio samples.
// Input beats arrive on in_valid_i / in_ready_o with sample_in_i; each
// produces exactly one output beat on out_valid_o / out_ready_i with
// sample_out_o. Coefficients and gains go over the APB port (index i
// at byte address 4*i); the user must write them only while no beat is
// in flight, which the block itself does not enforce. One shared
// digit-serial multiplier does all seven products in turn (input gain,
// five taps, output gain), each as a load state and then a run state
// over N digits of 4 bits, N = ceil(max(COEF_BITS, 25) / 4), 8 by
// default; one item is processed at a time.
// in_ready_o is high whenever the sequencer is idle, so the next beat is
// taken while a finished result still waits in the output register.
// If the receiver stalls, a second finished result waits in the
// sequencer until the output register frees.
// Reset clears the history to zero, loads the default coefficients
// (unity pass-through) and drops out_valid_o.
`timescale 1ns / 1ps

module biquad_lowpass_filter import biq_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int HO_W  = SAMPLE_BITS + 8;
  localparam int GN_W  = SAMPLE_BITS + 2;
  localparam int BW0   = (COEF_BITS > OUT_GAIN_W) ? COEF_BITS : OUT_GAIN_W + 1;
  localparam int DIG_N = (BW0 + DIGIT_W - 1) / DIGIT_W;
  localparam int B_W   = DIG_N * DIGIT_W;
  localparam int ACC_W = HO_W + B_W + 3;
  localparam int FILT_FRAC = COEF_BITS - 2;

  localparam logic signed [ACC_W-1:0] RND_IN   = ACC_W'(1) << (IN_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_FILT = ACC_W'(1) << (FILT_FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_OUT  = ACC_W'(1) << (OUT_FRAC - 1);

  localparam logic signed [HO_W-1:0] HO_MAX = {1'b0, {(HO_W-1){1'b1}}};
  localparam logic signed [HO_W-1:0] HO_MIN = {1'b1, {(HO_W-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [COEF_BITS-1:0] coef_ff0, coef_ff1, coef_ff2, coef_fb1, coef_fb2;
  logic [IN_GAIN_W-1:0]        in_gain;
  logic [OUT_GAIN_W-1:0]       out_gain;

  state_e state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [GN_W-1:0]        gained_q;
  logic signed [GN_W-1:0]        hist_in1_q, hist_in2_q;
  logic signed [HO_W-1:0]        hist_out1_q, hist_out2_q;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic                          out_valid_q;

  mac_cmd_t                mac_cmd;
  mac_sts_t                mac_sts;
  logic signed [HO_W-1:0]  mac_a;
  logic [B_W-1:0]          mac_b;
  logic signed [ACC_W-1:0] mac_init, mac_acc;

  logic signed [ACC_W-1:0] gain_sh, filt_sh, out_sh;
  logic signed [HO_W-1:0]  y_sat;
  logic signed [SAMPLE_BITS-1:0] o_sat;
  logic                    out_free;
  logic                    in_fire;

  biq_cfg #(
    .COEF_BITS (COEF_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .coef_ff0_o (coef_ff0),
    .coef_ff1_o (coef_ff1),
    .coef_ff2_o (coef_ff2),
    .coef_fb1_o (coef_fb1),
    .coef_fb2_o (coef_fb2),
    .in_gain_o  (in_gain),
    .out_gain_o (out_gain)
  );

  biq_mac #(
    .A_W   (HO_W),
    .DIG_N (DIG_N),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (mac_cmd),
    .a_i        (mac_a),
    .b_i        (mac_b),
    .acc_init_i (mac_init),
    .sts_o      (mac_sts),
    .acc_o      (mac_acc)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // rounding shifts and saturation of the accumulator
  assign gain_sh = mac_acc >>> IN_FRAC;
  assign filt_sh = mac_acc >>> FILT_FRAC;
  assign out_sh  = mac_acc >>> OUT_FRAC;

  always_comb begin
    if (&filt_sh[ACC_W-1:HO_W-1] || ~|filt_sh[ACC_W-1:HO_W-1]) begin
      y_sat = filt_sh[HO_W-1:0];
    end else if (filt_sh[ACC_W-1]) begin
      y_sat = HO_MIN;
    end else begin
      y_sat = HO_MAX;
    end
  end

  always_comb begin
    if (&out_sh[ACC_W-1:SAMPLE_BITS-1] || ~|out_sh[ACC_W-1:SAMPLE_BITS-1]) begin
      o_sat = out_sh[SAMPLE_BITS-1:0];
    end else if (out_sh[ACC_W-1]) begin
      o_sat = SMP_MIN;
    end else begin
      o_sat = SMP_MAX;
    end
  end

  // operand selection for the multiplier
  always_comb begin
    mac_cmd  = '0;
    mac_a    = HO_W'(sample_q);
    mac_b    = B_W'(in_gain);
    mac_init = RND_IN;
    case (state_q)
      S_LD_GAIN: begin
        mac_cmd.load     = 1'b1;
        mac_cmd.load_acc = 1'b1;
      end
      S_LD_TAP: begin
        mac_cmd.load     = 1'b1;
        mac_cmd.load_acc = (tap_q == TAP_FF0);
        mac_init         = RND_FILT;
      end
      S_LD_OUT: begin
        mac_cmd.load     = 1'b1;
        mac_cmd.load_acc = 1'b1;
        mac_init         = RND_OUT;
        mac_a            = hist_out1_q;
        mac_b            = B_W'(out_gain);
      end
      default: ;
    endcase
    if (state_q == S_LD_TAP) begin
      case (tap_q)
        TAP_FF0: begin
          mac_a = HO_W'(gained_q);
          mac_b = B_W'(coef_ff0);
        end
        TAP_FF1: begin
          mac_a = HO_W'(hist_in1_q);
          mac_b = B_W'(coef_ff1);
        end
        TAP_FF2: begin
          mac_a = HO_W'(hist_in2_q);
          mac_b = B_W'(coef_ff2);
        end
        TAP_FB1: begin
          mac_a = hist_out1_q;
          mac_b = B_W'(coef_fb1);
        end
        TAP_FB2: begin
          mac_a = hist_out2_q;
          mac_b = B_W'(coef_fb2);
        end
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    case (state_q)
      S_IDLE:     if (in_fire) state_d = S_LD_GAIN;
      S_LD_GAIN:  state_d = S_RUN_GAIN;
      S_RUN_GAIN: begin
        if (mac_sts.done) begin
          state_d = S_LD_TAP;
          tap_d   = TAP_FF0;
        end
      end
      S_LD_TAP:   state_d = S_RUN_TAP;
      S_RUN_TAP: begin
        if (mac_sts.done) begin
          if (tap_q == TAP_FB2) begin
            state_d = S_LD_OUT;
          end else begin
            state_d = S_LD_TAP;
            tap_d   = tap_q + 1'b1;
          end
        end
      end
      S_LD_OUT:   state_d = S_RUN_OUT;
      S_RUN_OUT:  if (mac_sts.done) state_d = S_FIN;
      S_FIN:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= TAP_FF0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  // input sample and gained sample
  always_ff @(posedge clk_i) begin
    if (in_fire) sample_q <= sample_in_i;
    if (state_q == S_RUN_GAIN && mac_sts.done) gained_q <= gain_sh[GN_W-1:0];
  end

  // filter history, shifted once the fifth tap is summed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_in1_q  <= '0;
      hist_in2_q  <= '0;
      hist_out1_q <= '0;
      hist_out2_q <= '0;
    end else if (state_q == S_RUN_TAP && mac_sts.done && tap_q == TAP_FB2) begin
      hist_in2_q  <= hist_in1_q;
      hist_in1_q  <= gained_q;
      hist_out2_q <= hist_out1_q;
      hist_out1_q <= y_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) out_q <= o_sat;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // checks
  default disable iff (!rst_ni);

  a_idle_mac_quiet: assert property (@(posedge clk_i) in_ready_o |-> !mac_sts.busy)
    else $error("multiplier busy while sequencer idle");

  a_done_in_run: assert property (@(posedge clk_i)
    mac_sts.done |-> (state_q == S_RUN_GAIN || state_q == S_RUN_TAP ||
                      state_q == S_RUN_OUT))
    else $error("multiplier finished outside a run state");

  a_out_from_fin: assert property (@(posedge clk_i)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("output beat raised without a finished item");

  a_accept_starts: assert property (@(posedge clk_i)
    in_fire |=> (state_q == S_LD_GAIN && mac_cmd.load))
    else $error("accepted beat did not start the gain product");

endmodule

// ===== tb/biquad_lowpass_filter_test.sv =====
// self-checking testbench for the biquad low-pass filter
`timescale 1ns / 1ps

module biquad_lowpass_filter_test;
  import biq_pkg::*;

  localparam int  SAMPLE_W    = 24;
  localparam int  SEGMENTS    = 12;
  localparam int  SEG_ITEMS   = 125;
  localparam int  TAIL_CYCLES = 200;
  localparam int  CYCLE_LIMIT = 4000000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] C_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN   = 32'h8000_0000;

  // predicts each filtered sample and checks the output beats in order
  class biquad_scoreboard;
    longint ff0, ff1, ff2, fb1, fb2;
    longint in_gain, out_gain;
    longint in_z1, in_z2, out_z1, out_z2;
    logic signed [SAMPLE_W-1:0] predicted_out[$];
    int mismatches, checked, accepted;

    function new();
      ff0 = 64'sd1 <<< 30;
      ff1 = 0;
      ff2 = 0;
      fb1 = 0;
      fb2 = 0;
      in_gain  = IN_GAIN_RST;
      out_gain = OUT_GAIN_RST;
      in_z1 = 0;
      in_z2 = 0;
      out_z1 = 0;
      out_z2 = 0;
      mismatches = 0;
      checked = 0;
      accepted = 0;
    endfunction

    function logic signed [127:0] widen(longint v);
      logic signed [127:0] w;
      w = v;
      return w;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      logic signed [31:0] sv;
      sv = v;
      case (idx)
        REG_FF0:      ff0 = sv;
        REG_FF1:      ff1 = sv;
        REG_FF2:      ff2 = sv;
        REG_FB1:      fb1 = sv;
        REG_FB2:      fb2 = sv;
        REG_IN_GAIN:  in_gain = v[IN_GAIN_W-1:0];
        REG_OUT_GAIN: out_gain = v[OUT_GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // run one sample through the filter and queue the scaled output
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint x, gained, y, o;
      logic signed [127:0] acc;
      x = s;
      gained = (x * in_gain + 64'sd16384) >>> IN_FRAC;
      acc = widen(ff0) * widen(gained) + widen(ff1) * widen(in_z1)
          + widen(ff2) * widen(in_z2) + widen(fb1) * widen(out_z1)
          + widen(fb2) * widen(out_z2);
      acc = (acc + widen(64'sd536870912)) >>> 30;
      // filter overflow clips the history value too
      if (acc > widen(64'sd2147483647)) y = 64'sd2147483647;
      else if (acc < widen(-64'sd2147483648)) y = -64'sd2147483648;
      else y = acc[63:0];
      out_z2 = out_z1;
      out_z1 = y;
      in_z2 = in_z1;
      in_z1 = gained;
      o = (y * out_gain + 64'sd524288) >>> OUT_FRAC;
      // output overflow
      if (o > 64'sd8388607) o = 64'sd8388607;
      else if (o < -64'sd8388608) o = -64'sd8388608;
      predicted_out.push_back(o[SAMPLE_W-1:0]);
      accepted++;
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (predicted_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("output beat %0d with nothing predicted", got);
      end else begin
        want = predicted_out.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %0d, got %0d", checked, want, got);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic in_ready;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [31:0] prdata;
  logic pready;

  biquad_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int settings_written = 0;
  int cycle_count = 0;

  biquad_lowpass_filter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always #5 clk = ~clk;

  // receiver: random stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_pct > 0 && $urandom_range(999) == 0) begin
      stall_left <= $urandom_range(20, 160);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_sample(sample_in);
      if (out_valid && out_ready) sb.check_sample(sample_out);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("biquad_lowpass_filter_test: done, errors");
    $finish;
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic apply_setting(input logic [31:0] f0, input logic [31:0] f1,
                               input logic [31:0] f2, input logic [31:0] b1,
                               input logic [31:0] b2, input logic [31:0] gi,
                               input logic [31:0] go);
    apb_write(REG_FF0, f0);
    apb_write(REG_FF1, f1);
    apb_write(REG_FF2, f2);
    apb_write(REG_FB1, b1);
    apb_write(REG_FB2, b2);
    apb_write(REG_IN_GAIN, gi);
    apb_write(REG_OUT_GAIN, go);
    settings_written++;
  endtask

  // one input beat, with an optional gap before it
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      gap = ($urandom_range(15) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off the sender until every predicted result has come out
  task automatic drain_filter();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // main sequence
  initial begin
    logic [31:0] reg_val [7];
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] last_s;
    longint a2q, lim, t;
    int seg, n, i;
    sb = new();
    last_s = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // pass-through at reset values, field extremes
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh000000);
    send_sample(-24'sh000001);
    send_sample(24'sh000001);
    send_sample(24'sh555555);
    send_sample(24'shAAAAAA);
    // write to an unmapped register is ignored
    drain_filter();
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_sample(24'sh7FFFFF);
    // everything at maximum: filter and output overflow
    drain_filter();
    apply_setting(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(-24'sh800000);
    send_sample(-24'sh800000);
    // most negative taps, gains with excess upper bits
    drain_filter();
    apply_setting(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 32'hABCD_8000, 32'hFF10_0000);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh000000);
    send_sample(24'sh003039);
    // zero gains
    drain_filter();
    apply_setting(Q30_ONE, '0, '0, '0, '0, '0, '0);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    // pass-through with the largest output gain
    drain_filter();
    apply_setting(Q30_ONE, '0, '0, '0, '0, 32'h0000_8000, 32'h00FF_FFFF);
    send_sample(24'sh0927C0);
    send_sample(-24'sh0927C0);
    send_sample(24'sh000064);

    // random segments, each with its own setting
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 58;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_filter();
      case ($urandom_range(3))
        0: begin
          // stable pole pair, modest feed-forward taps
          a2q = $urandom_range(0, 966367641);
          lim = ((64'sd1 <<< 30) + a2q) * 15 / 16;
          t = $urandom_range(0, 32'(2 * lim));
          for (i = 0; i < 3; i++) reg_val[i] = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
          reg_val[3] = 32'(t - lim);
          reg_val[4] = 32'(-a2q);
          reg_val[5] = $urandom();
          reg_val[6] = {8'($urandom_range(255)), 3'b000, 21'($urandom_range(0, 32'h1F_FFFF))};
        end
        1: begin
          for (i = 0; i < 7; i++) reg_val[i] = $urandom();
        end
        2: begin
          for (i = 0; i < 7; i++) begin
            case ($urandom_range(3))
              0: reg_val[i] = C_MAX;
              1: reg_val[i] = C_MIN;
              2: reg_val[i] = '0;
              default: reg_val[i] = 32'hFFFF_FFFF;
            endcase
          end
        end
        default: begin
          reg_val[0] = Q30_ONE;
          for (i = 1; i < 5; i++) reg_val[i] = '0;
          reg_val[5] = $urandom();
          reg_val[6] = $urandom();
        end
      endcase
      if ($urandom_range(3) == 0) apb_write(REG_UNUSED, $urandom());
      apply_setting(reg_val[0], reg_val[1], reg_val[2], reg_val[3], reg_val[4],
                    reg_val[5], reg_val[6]);
      for (n = 0; n < SEG_ITEMS; n++) begin
        case ($urandom_range(9))
          6, 7: s = SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
          8: begin
            case ($urandom_range(3))
              0: s = 24'sh7FFFFF;
              1: s = -24'sh800000;
              2: s = '0;
              default: s = -24'sh000001;
            endcase
          end
          9: s = last_s;
          default: s = SAMPLE_W'($urandom());
        endcase
        last_s = s;
        send_sample(s);
      end
    end

    // wrap up
    drain_filter();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.predicted_out.size() != 0) begin
      $display("%0d predicted results never came out", sb.predicted_out.size());
      sb.mismatches += sb.predicted_out.size();
    end
    $display("run covered %0d input samples and %0d checked outputs over %0d register settings",
             sb.accepted, sb.checked, settings_written);
    $display("%0d mismatches in %0d cycles", sb.mismatches, cycle_count);
    if (sb.mismatches == 0) begin
      $display("biquad_lowpass_filter_test: done, clean");
    end else begin
      $display("biquad_lowpass_filter_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== biquad_lowpass_filter.f =====
hdl/biq_pkg.sv
hdl/biq_cfg.sv
hdl/biq_mac.sv
hdl/biquad_lowpass_filter.sv
tb/biquad_lowpass_filter_test.sv
